// ===== rtl/bbgs_pkg.sv =====
package bbgs_pkg;

  // coordinate format
  localparam int FRAC_BITS  = 4;
  localparam int UNIT       = 1 << FRAC_BITS;
  localparam int COORD_W    = 16;
  localparam int ACUTE_W    = 8;
  localparam int WEIGHT_W   = 16;
  localparam int RADIUS_W   = 6;
  localparam int RADIUS_MAX = 32;
  localparam int COST_W     = 40;

  // stream payload widths
  localparam int IN_W  = 4 * COORD_W + 2 * ACUTE_W;
  localparam int OUT_W = 6 * COORD_W + COST_W;

  // config port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // internal widths: half-lsb coordinates with radius margin, grid indexes
  localparam int H_W     = COORD_W + 2;
  localparam int K_W     = H_W - FRAC_BITS + 1;
  localparam int E_W     = H_W + 3;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 2 * K_W;
  localparam int NUM_W   = SQ_W + WEIGHT_W;
  localparam int DIVN_W  = NUM_W + 2;
  localparam int DIVD_W  = SQ_W + 1;

  // width-slot cache, one entry per center-to-left distance
  localparam int SLOTS   = 257;
  localparam int CACHE_N = 2 * ((4 * RADIUS_MAX) / UNIT) + 3;
  localparam int CI_W    = $clog2(CACHE_N);

  localparam logic [COST_W-1:0] COST_CAP = '1;

  // register indexes
  localparam logic [2:0] REG_W_SYM    = 3'd0;
  localparam logic [2:0] REG_W_SIZE   = 3'd1;
  localparam logic [2:0] REG_W_POS    = 3'd2;
  localparam logic [2:0] REG_W_SHARP  = 3'd3;
  localparam logic [2:0] REG_W_ASPECT = 3'd4;
  localparam logic [2:0] REG_RADIUS   = 3'd5;

  typedef struct packed {
    logic signed [H_W-1:0] lo0;
    logic signed [H_W-1:0] mid0;
    logic signed [H_W-1:0] hi0;
    logic [ACUTE_W-1:0]    acute;
  } axis_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] sym;
    logic [WEIGHT_W-1:0] size;
    logic [WEIGHT_W-1:0] pos;
    logic [WEIGHT_W-1:0] sharp;
  } wts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XCHK,
    S_YCHK,
    S_YCOST,
    S_XCOST,
    S_DONE
  } seq_st_e;

  typedef enum logic [3:0] {
    C_IDLE,
    C_SQB,
    C_SQS,
    C_NUM,
    C_DSTART,
    C_DIV,
    C_SIZE,
    C_POS,
    C_SHARP,
    C_FIN
  } cost_st_e;

  // saturating cost add
  function automatic logic [COST_W-1:0] add_sat(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_CAP : s[COST_W-1:0];
  endfunction

  // clip a wide product to the cost range
  function automatic logic [COST_W-1:0] clamp_cost(input logic [PROD_W-1:0] v);
    return (|v[PROD_W-1:COST_W]) ? COST_CAP : v[COST_W-1:0];
  endfunction

endpackage

// ===== rtl/bbgs_div.sv =====
module bbgs_div #(
  parameter int N_W = bbgs_pkg::DIVN_W,
  parameter int D_W = bbgs_pkg::DIVD_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic           done_o,
  output logic [N_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N_W-1:0]   qn_q, qn_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic [D_W-1:0]   den_q, den_d;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     diff;
  logic             ge;

  // one restoring step per cycle, quotient bits shift in behind the numerator
  always_comb begin
    rem_sh = {rem_q, qn_q[N_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = (rem_sh >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    qn_d   = qn_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(N_W);
      qn_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
      qn_d  = {qn_q[N_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qn_q  <= qn_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = qn_q;

endmodule

// ===== rtl/bbgs_cost.sv =====
module bbgs_cost (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [bbgs_pkg::K_W-1:0] kl_i,
  input  logic signed [bbgs_pkg::K_W-1:0] km_i,
  input  logic signed [bbgs_pkg::K_W-1:0] kh_i,
  input  bbgs_pkg::axis_t              axis_i,
  input  bbgs_pkg::wts_t               wts_i,
  output logic                         done_o,
  output logic [bbgs_pkg::COST_W-1:0]  cost_o
);

  localparam int K_W    = bbgs_pkg::K_W;
  localparam int E_W    = bbgs_pkg::E_W;
  localparam int FB     = bbgs_pkg::FRAC_BITS;
  localparam int MUL_W  = bbgs_pkg::MUL_W;
  localparam int PROD_W = bbgs_pkg::PROD_W;
  localparam int SQ_W   = bbgs_pkg::SQ_W;
  localparam int NUM_W  = bbgs_pkg::NUM_W;
  localparam int DIVN_W = bbgs_pkg::DIVN_W;
  localparam int DIVD_W = bbgs_pkg::DIVD_W;
  localparam int COST_W = bbgs_pkg::COST_W;

  bbgs_pkg::cost_st_e st_q, st_d;

  logic [K_W-1:0]     big_q, big_d, sml_q, sml_d;
  logic [E_W-1:0]     ds_q, ds_d, pos_q, pos_d;
  logic               even_q, even_d;
  logic [bbgs_pkg::ACUTE_W-1:0] acute_q, acute_d;
  logic [SQ_W-1:0]    sqb_q, sqb_d, sqs_q, sqs_d;
  logic [PROD_W-1:0]  p_q, p_d;
  logic [COST_W-1:0]  acc_q, acc_d;
  logic [MUL_W-1:0]   mul_a, mul_b;

  logic               div_start, div_done;
  logic [DIVN_W-1:0]  div_num, div_quot;
  logic [DIVD_W-1:0]  div_den;

  logic signed [K_W:0]   f, s;
  logic signed [E_W-1:0] lv, mv, hv, dsv, dl, dm, dh;
  logic [PROD_W-1:0]     rnd_term;

  function automatic logic [E_W-1:0] abs_e(input logic signed [E_W-1:0] v);
    return v[E_W-1] ? E_W'(-v) : E_W'(v);
  endfunction

  bbgs_div #(
    .N_W (DIVN_W),
    .D_W (DIVD_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // operand prep from the candidate triple
  always_comb begin
    f   = (K_W+1)'(km_i) - (K_W+1)'(kl_i);
    s   = (K_W+1)'(kh_i) - (K_W+1)'(km_i);
    lv  = E_W'(kl_i) <<< FB;
    mv  = E_W'(km_i) <<< FB;
    hv  = E_W'(kh_i) <<< FB;
    dsv = (hv - lv) - (E_W'(axis_i.hi0) - E_W'(axis_i.lo0));
    dl  = lv - E_W'(axis_i.lo0);
    dm  = mv - E_W'(axis_i.mid0);
    dh  = hv - E_W'(axis_i.hi0);
  end

  // half-up rounding of a product over 2*UNIT
  assign rnd_term = (p_q + PROD_W'(bbgs_pkg::UNIT)) >> (FB + 1);

  // sequencer around the shared multiplier and the divider
  always_comb begin
    st_d      = st_q;
    big_d     = big_q;
    sml_d     = sml_q;
    ds_d      = ds_q;
    pos_d     = pos_q;
    even_d    = even_q;
    acute_d   = acute_q;
    sqb_d     = sqb_q;
    sqs_d     = sqs_q;
    acc_d     = acc_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = {p_q[NUM_W-1:0], 1'b0} + DIVN_W'(sqs_q);
    div_den   = {sqs_q, 1'b0};
    done_o    = 1'b0;
    cost_o    = bbgs_pkg::add_sat(acc_q, bbgs_pkg::clamp_cost(p_q));
    unique case (st_q)
      bbgs_pkg::C_IDLE: begin
        if (start_i) begin
          big_d   = (f > s) ? f[K_W-1:0] : s[K_W-1:0];
          sml_d   = (f > s) ? s[K_W-1:0] : f[K_W-1:0];
          ds_d    = abs_e(dsv);
          pos_d   = abs_e(dl) + abs_e(dm) + abs_e(dh);
          even_d  = !km_i[0];
          acute_d = axis_i.acute;
          st_d    = bbgs_pkg::C_SQB;
        end
      end
      bbgs_pkg::C_SQB: begin
        mul_a = MUL_W'(big_q);
        mul_b = MUL_W'(big_q);
        st_d  = bbgs_pkg::C_SQS;
      end
      bbgs_pkg::C_SQS: begin
        sqb_d = p_q[SQ_W-1:0];
        mul_a = MUL_W'(sml_q);
        mul_b = MUL_W'(sml_q);
        st_d  = bbgs_pkg::C_NUM;
      end
      bbgs_pkg::C_NUM: begin
        sqs_d = p_q[SQ_W-1:0];
        mul_a = MUL_W'(wts_i.sym);
        mul_b = MUL_W'(sqb_q);
        st_d  = bbgs_pkg::C_DSTART;
      end
      bbgs_pkg::C_DSTART: begin
        div_start = 1'b1;
        st_d      = bbgs_pkg::C_DIV;
      end
      bbgs_pkg::C_DIV: begin
        if (div_done) begin
          acc_d = bbgs_pkg::clamp_cost(PROD_W'(div_quot));
          st_d  = bbgs_pkg::C_SIZE;
        end
      end
      bbgs_pkg::C_SIZE: begin
        mul_a = MUL_W'(wts_i.size);
        mul_b = MUL_W'(ds_q);
        st_d  = bbgs_pkg::C_POS;
      end
      bbgs_pkg::C_POS: begin
        acc_d = bbgs_pkg::add_sat(acc_q, bbgs_pkg::clamp_cost(rnd_term));
        mul_a = MUL_W'(wts_i.pos);
        mul_b = MUL_W'(pos_q);
        st_d  = bbgs_pkg::C_SHARP;
      end
      bbgs_pkg::C_SHARP: begin
        acc_d = bbgs_pkg::add_sat(acc_q, bbgs_pkg::clamp_cost(rnd_term));
        mul_a = MUL_W'(wts_i.sharp);
        mul_b = even_q ? MUL_W'(acute_q) : '0;
        st_d  = bbgs_pkg::C_FIN;
      end
      bbgs_pkg::C_FIN: begin
        done_o = 1'b1;
        st_d   = bbgs_pkg::C_IDLE;
      end
      default: st_d = bbgs_pkg::C_IDLE;
    endcase
    p_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bbgs_pkg::C_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    big_q   <= big_d;
    sml_q   <= sml_d;
    ds_q    <= ds_d;
    pos_q   <= pos_d;
    even_q  <= even_d;
    acute_q <= acute_d;
    sqb_q   <= sqb_d;
    sqs_q   <= sqs_d;
    acc_q   <= acc_d;
    p_q     <= p_d;
  end

endmodule

// ===== rtl/bounding_box_grid_snap_search_top.sv =====
// Grid-snap search for one bounding box per request. Each request is scored
// over every edge-center-edge candidate on both axes and returns the cheapest
// triple pair, a found flag and its cost. The block takes one request at a
// time: s_axis_tready_o is high only between requests, while a finished
// result may still wait in the output register. One candidate scoring pass
// runs on a shared multiplier and a one-bit-per-cycle divider; scan steps that
// skip a candidate do not use it. Y triples are scored once per distinct
// center-to-left width on X. The default radius is 16; at radius 32 the worst
// case is near 4000 scored triples. Weights and radius are written over APB at
// byte address 4*index; the user must write them only between requests, as the
// block does not enforce it.
module bounding_box_grid_snap_search_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // left_x, right_x, top_y, bottom_y, acute_x, acute_y
  input  logic [bbgs_pkg::IN_W-1:0]      s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // best_left, best_mid_x, best_right, best_top, best_mid_y, best_bottom, best_cost
  output logic [bbgs_pkg::OUT_W-1:0]     m_axis_tdata_o,
  // found
  output logic                           m_axis_tuser_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bbgs_pkg::APB_AW-1:0]    paddr,
  input  logic [bbgs_pkg::APB_DW-1:0]    pwdata,
  output logic [bbgs_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  localparam int K_W     = bbgs_pkg::K_W;
  localparam int H_W     = bbgs_pkg::H_W;
  localparam int FB      = bbgs_pkg::FRAC_BITS;
  localparam int CW      = bbgs_pkg::COORD_W;
  localparam int COST_W  = bbgs_pkg::COST_W;
  localparam int WW      = bbgs_pkg::WEIGHT_W;
  localparam int RW      = bbgs_pkg::RADIUS_W;
  localparam int CACHE_N = bbgs_pkg::CACHE_N;
  localparam int CI_W    = bbgs_pkg::CI_W;
  localparam int SL_W    = K_W + FB + 3;
  localparam int AW      = bbgs_pkg::ACUTE_W;

  typedef struct packed {
    logic signed [K_W-1:0] la;
    logic signed [K_W-1:0] lb;
    logic signed [K_W-1:0] ma;
    logic signed [K_W-1:0] mb;
    logic signed [K_W-1:0] ha;
    logic signed [K_W-1:0] hb;
  } range_t;

  // ---------------------------------------------------------------- config
  logic [WW-1:0] wsym_q, wsize_q, wpos_q, wsharp_q, wasp_q;
  logic [RW-1:0] rad_q;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsym_q   <= WW'(256);
      wsize_q  <= WW'(256);
      wpos_q   <= WW'(256);
      wsharp_q <= WW'(256);
      wasp_q   <= WW'(256);
      rad_q    <= RW'(16);
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        bbgs_pkg::REG_W_SYM:    wsym_q   <= pwdata[WW-1:0];
        bbgs_pkg::REG_W_SIZE:   wsize_q  <= pwdata[WW-1:0];
        bbgs_pkg::REG_W_POS:    wpos_q   <= pwdata[WW-1:0];
        bbgs_pkg::REG_W_SHARP:  wsharp_q <= pwdata[WW-1:0];
        bbgs_pkg::REG_W_ASPECT: wasp_q   <= pwdata[WW-1:0];
        bbgs_pkg::REG_RADIUS:   rad_q    <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[4:2])
      bbgs_pkg::REG_W_SYM:    prdata = bbgs_pkg::APB_DW'(wsym_q);
      bbgs_pkg::REG_W_SIZE:   prdata = bbgs_pkg::APB_DW'(wsize_q);
      bbgs_pkg::REG_W_POS:    prdata = bbgs_pkg::APB_DW'(wpos_q);
      bbgs_pkg::REG_W_SHARP:  prdata = bbgs_pkg::APB_DW'(wsharp_q);
      bbgs_pkg::REG_W_ASPECT: prdata = bbgs_pkg::APB_DW'(wasp_q);
      bbgs_pkg::REG_RADIUS:   prdata = bbgs_pkg::APB_DW'(rad_q);
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------- helpers
  function automatic logic signed [K_W-1:0] k_lo(input logic signed [H_W-1:0] v,
                                                 input logic signed [H_W-1:0] r2s,
                                                 input logic odd_fix);
    logic signed [H_W-1:0] t;
    logic signed [H_W-1:0] q;
    logic signed [K_W-1:0] k;
    t = r2s - v;
    q = -(t >>> FB);
    k = K_W'(q);
    if (odd_fix && !k[0]) k = k + K_W'(1);
    return k;
  endfunction

  function automatic logic signed [K_W-1:0] k_hi(input logic signed [H_W-1:0] v,
                                                 input logic signed [H_W-1:0] r2s);
    logic signed [H_W-1:0] q;
    q = (v + r2s) >>> FB;
    return K_W'(q);
  endfunction

  function automatic logic old_square(input logic signed [CW:0] w,
                                      input logic signed [CW:0] h);
    logic signed [CW:0] mn, mx;
    logic [CW+7:0]      a, b;
    mn = (w < h) ? w : h;
    mx = (w < h) ? h : w;
    a  = (CW+8)'($unsigned(mx)) * (CW+8)'(100);
    b  = (CW+8)'($unsigned(mn)) * (CW+8)'(101);
    if (mn < 0) return 1'b1;
    if (mn == 0) return (mx == 0);
    return a < b;
  endfunction

  function automatic logic cand_square(input logic [K_W-1:0] d1,
                                       input logic [K_W-1:0] d2);
    logic [K_W-1:0] mn, mx;
    logic [K_W+6:0] a, b;
    mn = (d1 < d2) ? d1 : d2;
    mx = (d1 < d2) ? d2 : d1;
    a  = (K_W+7)'(mx) * (K_W+7)'(100);
    b  = (K_W+7)'(mn) * (K_W+7)'(101);
    return a < b;
  endfunction

  function automatic logic usable(input logic signed [K_W-1:0] kl,
                                  input logic signed [K_W-1:0] km,
                                  input logic signed [K_W-1:0] kh);
    logic signed [K_W:0] sm;
    sm = (K_W+1)'(kl) + (K_W+1)'(kh);
    return (kl < km) && (km < kh) && !(sm[1] && !km[0]);
  endfunction

  function automatic logic [CW-1:0] coord_of(input logic signed [K_W-1:0] k);
    logic signed [K_W+FB-1:0] w;
    w = (K_W+FB)'(k) <<< (FB - 1);
    return w[CW-1:0];
  endfunction

  // ------------------------------------------------------------ item setup
  logic signed [CW-1:0]  x1, x2, y1, y2;
  logic [RW-1:0]         rcl;
  logic signed [H_W-1:0] r2s;
  bbgs_pkg::axis_t       ax_in, ay_in;
  range_t                rx_in, ry_in;

  always_comb begin
    x1  = $signed(s_axis_tdata_i[CW-1:0]);
    x2  = $signed(s_axis_tdata_i[2*CW-1:CW]);
    y1  = $signed(s_axis_tdata_i[3*CW-1:2*CW]);
    y2  = $signed(s_axis_tdata_i[4*CW-1:3*CW]);
    rcl = (rad_q == '0) ? RW'(1) :
          ((rad_q > RW'(bbgs_pkg::RADIUS_MAX)) ? RW'(bbgs_pkg::RADIUS_MAX) : rad_q);
    r2s = $signed(H_W'({rcl, 1'b0}));
    ax_in.lo0   = H_W'(x1) <<< 1;
    ax_in.mid0  = H_W'(x1) + H_W'(x2);
    ax_in.hi0   = H_W'(x2) <<< 1;
    ax_in.acute = s_axis_tdata_i[4*CW+AW-1:4*CW];
    ay_in.lo0   = H_W'(y1) <<< 1;
    ay_in.mid0  = H_W'(y1) + H_W'(y2);
    ay_in.hi0   = H_W'(y2) <<< 1;
    ay_in.acute = s_axis_tdata_i[4*CW+2*AW-1:4*CW+AW];
    rx_in.la = k_lo(ax_in.lo0, r2s, 1'b1);
    rx_in.lb = k_hi(ax_in.lo0, r2s);
    rx_in.ma = k_lo(ax_in.mid0, r2s, 1'b0);
    rx_in.mb = k_hi(ax_in.mid0, r2s);
    rx_in.ha = k_lo(ax_in.hi0, r2s, 1'b1);
    rx_in.hb = k_hi(ax_in.hi0, r2s);
    ry_in.la = k_lo(ay_in.lo0, r2s, 1'b1);
    ry_in.lb = k_hi(ay_in.lo0, r2s);
    ry_in.ma = k_lo(ay_in.mid0, r2s, 1'b0);
    ry_in.mb = k_hi(ay_in.mid0, r2s);
    ry_in.ha = k_lo(ay_in.hi0, r2s, 1'b1);
    ry_in.hb = k_hi(ay_in.hi0, r2s);
  end

  // ------------------------------------------------------------ sequencer
  bbgs_pkg::seq_st_e st_q, st_d;
  bbgs_pkg::axis_t   ax_q, ax_d, ay_q, ay_d;
  range_t            rx_q, rx_d, ry_q, ry_d;
  logic              old_sq_q, old_sq_d;
  logic [RW+1:0]     r4_q, r4_d;
  logic signed [K_W:0]   dmin_q, dmin_d;
  logic signed [K_W-1:0] kl_q, kl_d, km_q, km_d, kh_q, kh_d;
  logic signed [K_W-1:0] tl_q, tl_d, tm_q, tm_d, th_q, th_d;
  logic [CI_W-1:0]   idx_q, idx_d;
  logic [K_W-1:0]    dx_q, dx_d;
  logic [CACHE_N-1:0] seen_q, seen_d, okay_q, okay_d;
  logic              found_q, found_d;
  logic [COST_W-1:0] best_q, best_d;
  logic signed [K_W-1:0] bk_q [6];
  logic              best_we;

  logic [COST_W-1:0]     ycost_q [CACHE_N];
  logic signed [K_W-1:0] yt_q [CACHE_N];
  logic signed [K_W-1:0] ym_q [CACHE_N];
  logic signed [K_W-1:0] yb_q [CACHE_N];
  logic                  cache_we;

  logic              m_valid_q, m_valid_d, out_load;
  logic [bbgs_pkg::OUT_W-1:0] mdata_q;
  logic              muser_q;

  logic              cost_start, cost_sel_y, cost_done;
  logic [COST_W-1:0] cost_val, cy, total;
  logic signed [K_W-1:0] c_kl, c_km, c_kh;
  bbgs_pkg::axis_t   c_axis;
  bbgs_pkg::wts_t    wts;

  logic signed [K_W:0]    d, idxw, dyw;
  logic signed [SL_W-1:0] slot, w0;
  logic                   slot_ok;
  logic [K_W-1:0]         dy;

  assign wts = '{sym: wsym_q, size: wsize_q, pos: wpos_q, sharp: wsharp_q};

  // shared scoring unit, fed with the X or the Y triple
  assign c_kl   = cost_sel_y ? tl_q : kl_q;
  assign c_km   = cost_sel_y ? tm_q : km_q;
  assign c_kh   = cost_sel_y ? th_q : kh_q;
  assign c_axis = cost_sel_y ? ay_q : ax_q;

  bbgs_cost u_cost (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cost_start),
    .kl_i    (c_kl),
    .km_i    (c_km),
    .kh_i    (c_kh),
    .axis_i  (c_axis),
    .wts_i   (wts),
    .done_o  (cost_done),
    .cost_o  (cost_val)
  );

  // width slot of the current X triple, aspect-adjusted Y cost and pair total
  always_comb begin
    d       = (K_W+1)'(km_q) - (K_W+1)'(kl_q);
    w0      = SL_W'(ax_q.mid0) - SL_W'(ax_q.lo0);
    slot    = (SL_W'(d) <<< FB) - w0 + $signed(SL_W'(r4_q));
    slot_ok = (slot >= 0) && (slot < SL_W'(bbgs_pkg::SLOTS));
    idxw    = d - dmin_q;
    dyw     = (K_W+1)'(tm_q) - (K_W+1)'(tl_q);
    dy      = dyw[K_W-1:0];
    cy      = bbgs_pkg::add_sat(cost_val,
                (old_sq_q && !cand_square(dx_q, dy)) ? COST_W'(wasp_q) : '0);
    total   = bbgs_pkg::add_sat(cost_val, ycost_q[idx_q]);
  end

  // next state and loop counters
  always_comb begin
    st_d       = st_q;
    ax_d       = ax_q;
    ay_d       = ay_q;
    rx_d       = rx_q;
    ry_d       = ry_q;
    old_sq_d   = old_sq_q;
    r4_d       = r4_q;
    dmin_d     = dmin_q;
    kl_d       = kl_q;
    km_d       = km_q;
    kh_d       = kh_q;
    tl_d       = tl_q;
    tm_d       = tm_q;
    th_d       = th_q;
    idx_d      = idx_q;
    dx_d       = dx_q;
    seen_d     = seen_q;
    okay_d     = okay_q;
    found_d    = found_q;
    best_d     = best_q;
    best_we    = 1'b0;
    cache_we   = 1'b0;
    cost_start = 1'b0;
    cost_sel_y = 1'b0;
    out_load   = 1'b0;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    s_axis_tready_o = 1'b0;
    unique case (st_q)
      bbgs_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          ax_d     = ax_in;
          ay_d     = ay_in;
          rx_d     = rx_in;
          ry_d     = ry_in;
          old_sq_d = old_square((CW+1)'(x2) - (CW+1)'(x1), (CW+1)'(y2) - (CW+1)'(y1));
          r4_d     = {rcl, 2'b00};
          dmin_d   = (K_W+1)'(rx_in.ma) - (K_W+1)'(rx_in.lb);
          kl_d     = rx_in.la;
          kh_d     = rx_in.ha;
          km_d     = rx_in.ma;
          seen_d   = '0;
          okay_d   = '0;
          found_d  = 1'b0;
          best_d   = '0;
          st_d     = bbgs_pkg::S_XCHK;
        end
      end
      bbgs_pkg::S_XCHK: begin
        if (kl_q > rx_q.lb) begin
          st_d = bbgs_pkg::S_DONE;
        end else if (kh_q > rx_q.hb) begin
          kl_d = kl_q + K_W'(2);
          kh_d = rx_q.ha;
          km_d = rx_q.ma;
        end else if (km_q > rx_q.mb) begin
          kh_d = kh_q + K_W'(2);
          km_d = rx_q.ma;
        end else if (usable(kl_q, km_q, kh_q) && slot_ok) begin
          idx_d = idxw[CI_W-1:0];
          dx_d  = d[K_W-1:0];
          if (!seen_q[idxw[CI_W-1:0]]) begin
            seen_d[idxw[CI_W-1:0]] = 1'b1;
            tl_d = ry_q.la;
            th_d = ry_q.ha;
            tm_d = ry_q.ma;
            st_d = bbgs_pkg::S_YCHK;
          end else if (okay_q[idxw[CI_W-1:0]]) begin
            cost_start = 1'b1;
            st_d       = bbgs_pkg::S_XCOST;
          end else begin
            km_d = km_q + K_W'(1);
          end
        end else begin
          km_d = km_q + K_W'(1);
        end
      end
      bbgs_pkg::S_YCHK: begin
        if (tl_q > ry_q.lb) begin
          if (okay_q[idx_q]) begin
            cost_start = 1'b1;
            st_d       = bbgs_pkg::S_XCOST;
          end else begin
            km_d = km_q + K_W'(1);
            st_d = bbgs_pkg::S_XCHK;
          end
        end else if (th_q > ry_q.hb) begin
          tl_d = tl_q + K_W'(2);
          th_d = ry_q.ha;
          tm_d = ry_q.ma;
        end else if (tm_q > ry_q.mb) begin
          th_d = th_q + K_W'(2);
          tm_d = ry_q.ma;
        end else if (usable(tl_q, tm_q, th_q)) begin
          cost_start = 1'b1;
          cost_sel_y = 1'b1;
          st_d       = bbgs_pkg::S_YCOST;
        end else begin
          tm_d = tm_q + K_W'(1);
        end
      end
      bbgs_pkg::S_YCOST: begin
        if (cost_done) begin
          if (!okay_q[idx_q] || (cy < ycost_q[idx_q])) begin
            okay_d[idx_q] = 1'b1;
            cache_we      = 1'b1;
          end
          tm_d = tm_q + K_W'(1);
          st_d = bbgs_pkg::S_YCHK;
        end
      end
      bbgs_pkg::S_XCOST: begin
        if (cost_done) begin
          if (!found_q || (total < best_q)) begin
            found_d = 1'b1;
            best_d  = total;
            best_we = 1'b1;
          end
          km_d = km_q + K_W'(1);
          st_d = bbgs_pkg::S_XCHK;
        end
      end
      bbgs_pkg::S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          st_d      = bbgs_pkg::S_IDLE;
        end
      end
      default: st_d = bbgs_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= bbgs_pkg::S_IDLE;
      seen_q    <= '0;
      okay_q    <= '0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      seen_q    <= seen_d;
      okay_q    <= okay_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
    end
  end

  // item and loop registers
  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    old_sq_q <= old_sq_d;
    r4_q     <= r4_d;
    dmin_q   <= dmin_d;
    kl_q     <= kl_d;
    km_q     <= km_d;
    kh_q     <= kh_d;
    tl_q     <= tl_d;
    tm_q     <= tm_d;
    th_q     <= th_d;
    idx_q    <= idx_d;
    dx_q     <= dx_d;
    best_q   <= best_d;
  end

  // best Y triple per width slot
  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      ycost_q[idx_q] <= cy;
      yt_q[idx_q]    <= tl_q;
      ym_q[idx_q]    <= tm_q;
      yb_q[idx_q]    <= th_q;
    end
  end

  // best pair so far
  always_ff @(posedge clk_i) begin
    if (best_we) begin
      bk_q[0] <= kl_q;
      bk_q[1] <= km_q;
      bk_q[2] <= kh_q;
      bk_q[3] <= yt_q[idx_q];
      bk_q[4] <= ym_q[idx_q];
      bk_q[5] <= yb_q[idx_q];
    end
  end

  // output register, zeros when nothing was found
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      muser_q <= found_q;
      if (found_q) begin
        mdata_q <= {best_q, coord_of(bk_q[5]), coord_of(bk_q[4]), coord_of(bk_q[3]),
                    coord_of(bk_q[2]), coord_of(bk_q[1]), coord_of(bk_q[0])};
      end else begin
        mdata_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

endmodule

// ===== sim/bbgs_checker.sv =====
`timescale 1ns / 100ps

// watches both stream channels, predicts each box result and compares
module bbgs_checker
  import bbgs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [IN_W-1:0]      s_axis_tdata_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [OUT_W-1:0]     m_axis_tdata_i,
  input  logic                 m_axis_tuser_i,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  input  logic                 pready,
  output int                   fail_count,
  output int                   pending_count
);

  localparam longint CAP = 64'hFF_FFFF_FFFF;

  typedef struct {
    logic [OUT_W-1:0] data;
    logic             found;
  } snap_result_t;

  snap_result_t snap_expect_q[$];

  logic [WEIGHT_W-1:0] w_sym, w_size, w_pos, w_sharp, w_aspect;
  logic [RADIUS_W-1:0] radius;

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    if (a > CAP) a = CAP;
    if (b > CAP) b = CAP;
    s = a + b;
    return s > CAP ? CAP : s;
  endfunction

  function automatic longint round_div(longint num, longint den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic longint abs64(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic bit is_square(longint w, longint h);
    longint mn, mx;
    mn = w < h ? w : h;
    mx = w < h ? h : w;
    if (mn < 0) return 1;
    if (mn == 0) return mx == 0;
    return 100 * mx < 101 * mn;
  endfunction

  function automatic bit is_odd(longint k);
    return k[0];
  endfunction

  // an ordered triple whose ends center on a pixel needs a pixel-center middle
  function automatic bit triple_ok(longint kl, longint km, longint kh);
    if (!(kl < km && km < kh)) return 0;
    return !(is_odd((kl + kh) / 2) && !is_odd(km));
  endfunction

  // score of one axis triple, all in half-lsb units
  function automatic longint triple_cost(longint lo0, longint mid0, longint hi0,
                                         longint acute, longint kl, longint km,
                                         longint kh);
    longint l, m, h, f, s, big, sml, c, ds, pos;
    l = kl * UNIT; m = km * UNIT; h = kh * UNIT;
    f = m - l; s = h - m;
    big = f > s ? f : s;
    sml = f > s ? s : f;
    c = round_div(longint'(w_sym) * big * big, sml * sml);
    ds = abs64((h - l) - (hi0 - lo0));
    pos = abs64(l - lo0) + abs64(m - mid0) + abs64(h - hi0);
    c = sat_add(c, round_div(longint'(w_size) * ds, 2 * UNIT));
    c = sat_add(c, round_div(longint'(w_pos) * pos, 2 * UNIT));
    if (!is_odd(km)) c = sat_add(c, longint'(w_sharp) * acute);
    return c;
  endfunction

  // full grid-snap search over both axes
  function automatic snap_result_t snap_search(logic [IN_W-1:0] d);
    longint x1, x2, y1, y2, ax_acute, ay_acute, r, r2;
    longint xlo, xmid, xhi, ylo, ymid, yhi;
    longint xla, xlb, xma, xmb, xha, xhb, yla, ylb, yma, ymb, yha, yhb;
    longint kl, km, kh, tl, tm, th, wx, slot, w0, cx, cy, total, best;
    longint b[6];
    bit seen[257], okay[257];
    longint ycost[257], yt[257], ym[257], yb[257];
    bit old_sq, found;
    snap_result_t res;
    x1 = longint'($signed(d[15:0]));
    x2 = longint'($signed(d[31:16]));
    y1 = longint'($signed(d[47:32]));
    y2 = longint'($signed(d[63:48]));
    ax_acute = d[71:64];
    ay_acute = d[79:72];
    r = radius < 1 ? 1 : (radius > RADIUS_MAX ? RADIUS_MAX : radius);
    r2 = 2 * r;
    old_sq = is_square(x2 - x1, y2 - y1);
    xlo = 2 * x1; xmid = x1 + x2; xhi = 2 * x2;
    ylo = 2 * y1; ymid = y1 + y2; yhi = 2 * y2;
    xla = -floor_div(-(xlo - r2), UNIT); xlb = floor_div(xlo + r2, UNIT);
    xma = -floor_div(-(xmid - r2), UNIT); xmb = floor_div(xmid + r2, UNIT);
    xha = -floor_div(-(xhi - r2), UNIT); xhb = floor_div(xhi + r2, UNIT);
    yla = -floor_div(-(ylo - r2), UNIT); ylb = floor_div(ylo + r2, UNIT);
    yma = -floor_div(-(ymid - r2), UNIT); ymb = floor_div(ymid + r2, UNIT);
    yha = -floor_div(-(yhi - r2), UNIT); yhb = floor_div(yhi + r2, UNIT);
    if (!is_odd(xla)) xla++;
    if (!is_odd(xha)) xha++;
    if (!is_odd(yla)) yla++;
    if (!is_odd(yha)) yha++;
    w0 = xmid - xlo;
    found = 0; best = 0;
    foreach (b[i]) b[i] = 0;
    foreach (seen[i]) begin
      seen[i] = 0; okay[i] = 0; ycost[i] = 0;
    end
    for (kl = xla; kl <= xlb; kl += 2)
      for (kh = xha; kh <= xhb; kh += 2)
        for (km = xma; km <= xmb; km++) begin
          if (!triple_ok(kl, km, kh)) continue;
          wx = (km - kl) * UNIT;
          slot = wx - w0 + 4 * r;
          if (slot < 0 || slot >= 257) continue;
          // best y triple per distinct x half width
          if (!seen[slot]) begin
            seen[slot] = 1;
            for (tl = yla; tl <= ylb; tl += 2)
              for (th = yha; th <= yhb; th += 2)
                for (tm = yma; tm <= ymb; tm++) begin
                  if (!triple_ok(tl, tm, th)) continue;
                  cy = triple_cost(ylo, ymid, yhi, ay_acute, tl, tm, th);
                  if (old_sq && !is_square(wx, (tm - tl) * UNIT))
                    cy = sat_add(cy, longint'(w_aspect));
                  if (!okay[slot] || cy < ycost[slot]) begin
                    okay[slot] = 1; ycost[slot] = cy;
                    yt[slot] = tl; ym[slot] = tm; yb[slot] = th;
                  end
                end
          end
          if (!okay[slot]) continue;
          cx = triple_cost(xlo, xmid, xhi, ax_acute, kl, km, kh);
          total = sat_add(cx, ycost[slot]);
          if (!found || total < best) begin
            found = 1; best = total;
            b[0] = kl; b[1] = km; b[2] = kh;
            b[3] = yt[slot]; b[4] = ym[slot]; b[5] = yb[slot];
          end
        end
    res.data = '0;
    if (found) begin
      for (int i = 0; i < 6; i++) begin
        longint v;
        v = b[i] * (UNIT / 2);
        res.data[16*i +: 16] = v[15:0];
      end
      res.data[96 +: COST_W] = best[COST_W-1:0];
    end
    res.found = found;
    return res;
  endfunction

  assign pending_count = snap_expect_q.size();

  // register shadow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_sym <= 16'd256; w_size <= 16'd256; w_pos <= 16'd256;
      w_sharp <= 16'd256; w_aspect <= 16'd256; radius <= 6'd16;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_W_SYM:    w_sym <= pwdata[15:0];
        REG_W_SIZE:   w_size <= pwdata[15:0];
        REG_W_POS:    w_pos <= pwdata[15:0];
        REG_W_SHARP:  w_sharp <= pwdata[15:0];
        REG_W_ASPECT: w_aspect <= pwdata[15:0];
        REG_RADIUS:   radius <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // predict on request, compare on result
  always @(posedge clk_i) begin
    snap_result_t exp_r;
    if (!rst_ni) begin
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        snap_expect_q.push_back(snap_search(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (snap_expect_q.size() == 0) begin
          $display("%0t: unexpected result data=%h found=%b", $time,
                   m_axis_tdata_i, m_axis_tuser_i);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = snap_expect_q.pop_front();
          if (exp_r.data !== m_axis_tdata_i || exp_r.found !== m_axis_tuser_i) begin
            $display("%0t: mismatch expected data=%h found=%b actual data=%h found=%b",
                     $time, exp_r.data, exp_r.found, m_axis_tdata_i, m_axis_tuser_i);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bbgs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit gen_done = 0;

  localparam int IDLE_LIMIT = 600000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bounding_box_grid_snap_search_top uut (.*);

  bbgs_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_count
  );

  // register write, setup then access
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one request, with an optional random gap after it
  task automatic send_box(logic signed [15:0] l, logic signed [15:0] r,
                          logic signed [15:0] t, logic signed [15:0] b,
                          logic [7:0] ax, logic [7:0] ay);
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {ay, ax, b, t, r, l};
    do @(posedge clk_i); while (!s_axis_tready_o);
    s_axis_tvalid_i <= 1'b0;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_box(int span);
    logic signed [15:0] l, t;
    l = $urandom;
    t = $urandom;
    if ($urandom_range(0, 3) == 0)
      send_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send_box(l, l + $urandom_range(0, span), t, t + $urandom_range(0, span),
               $urandom, $urandom);
  endtask

  // receiver stall pattern, plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else if (($time / 12000) % 2 == 0) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 2) != 0);
  end

  // watchdog on accepted handshakes
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("bounding_box_grid_snap_search_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: defaults, extremes, degenerate and inverted boxes
    send_box(16'sd0, 16'sd64, 16'sd0, 16'sd64, 8'd0, 8'd0);
    send_box(16'sd8, 16'sd56, 16'sd8, 16'sd40, 8'd255, 8'd255);
    send_box(16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd3, 8'd3);
    send_box(16'sd64, 16'sd0, 16'sd32, 16'sd0, 8'd1, 8'd2);
    send_box(-16'sd32768, -16'sd32700, 16'sd32700, 16'sd32767, 8'd7, 8'd9);
    send_box(16'sd32760, 16'sd32767, -16'sd32768, -16'sd32760, 8'd128, 8'd1);
    send_box(-16'sd5, 16'sd27, 16'sd3, 16'sd35, 8'd10, 8'd0);
    send_box(16'sd0, 16'sd33, 16'sd0, 16'sd32, 8'd0, 8'd5);
    drain();
    // extreme weights, smallest radius
    reg_write(REG_W_SYM, 32'hFFFF);
    reg_write(REG_W_SIZE, 32'h0);
    reg_write(REG_W_POS, 32'hFFFF);
    reg_write(REG_W_SHARP, 32'hFFFF);
    reg_write(REG_W_ASPECT, 32'h0);
    reg_write(REG_RADIUS, 32'd0);
    send_box(16'sd0, 16'sd64, 16'sd0, 16'sd64, 8'd255, 8'd0);
    send_box(16'sd4, 16'sd60, 16'sd2, 16'sd30, 8'd0, 8'd255);
    for (int i = 0; i < 15; i++) random_box(80);
    drain();
    // largest radius, a few boxes only
    reg_write(REG_RADIUS, 32'd63);
    reg_write(REG_W_ASPECT, 32'hFFFF);
    reg_write(REG_W_SIZE, 32'hFFFF);
    send_box(16'sd0, 16'sd64, 16'sd0, 16'sd64, 8'd1, 8'd1);
    random_box(60);
    drain();
    // long receiver hold-off while requests keep coming
    reg_write(REG_RADIUS, 32'd8);
    hold_off = 1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 4; i++) random_box(60);
    join
    drain();
    // random weights and radius in phases
    for (int p = 0; p < 6; p++) begin
      reg_write(REG_W_SYM, $urandom_range(0, 65535));
      reg_write(REG_W_SIZE, $urandom_range(0, 65535));
      reg_write(REG_W_POS, $urandom_range(0, 65535));
      reg_write(REG_W_SHARP, $urandom_range(0, 65535));
      reg_write(REG_W_ASPECT, $urandom_range(0, 65535));
      reg_write(REG_RADIUS, $urandom_range(1, 16));
      for (int i = 0; i < 12; i++) random_box(120);
      drain();
    end
    gen_done = 1;
    if (fail_count == 0)
      $display("bounding_box_grid_snap_search_top verification clean");
    else
      $display("bounding_box_grid_snap_search_top verification failed");
    $finish;
  end

endmodule
